// File: rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

  localparam int unsigned VOICES       = 8;
  localparam int unsigned SAMPLE_WORDS = 65536;

  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned ADDR_W = $clog2(SAMPLE_WORDS);
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned PHASE_W  = 9;
  localparam int unsigned SPEED_W  = 8;
  // sum of all voices plus headroom
  localparam int unsigned SUM_W    = SAMPLE_W + VIDX_W + 2;

  localparam logic signed [PHASE_W-1:0] PHASE_HI = 9'sd100;
  localparam logic signed [PHASE_W-1:0] PHASE_LO = -9'sd100;

  localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] MIX_MIN = -SUM_W'(32768);

  localparam logic [15:0] DAC_CTRL  = 16'h3000;
  localparam logic [15:0] DAC_MASK  = 16'h0FFF;
  localparam logic [15:0] SIGN_FLIP = 16'h8000;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_QUEUE      = 2'd1,
    CMD_QUEUE_ONCE = 2'd2,
    CMD_LOAD       = 2'd3
  } cmd_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CLAIM = 6'b000100,
    S_TRD   = 6'b001000,
    S_TACC  = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

endpackage

// File: rtl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// Voice table, sample memory and tick mixer with a change-only DAC output.
// ----------------------------------------------------------------------------
// A load transaction writes the sample memory and returns straight to idle. A
// queue transaction scans the voice table one voice per cycle and then claims
// the first free voice. A tick visits the voices in turn through a single
// sample memory read port: a playing voice takes a registered read, then an
// accumulate and advance step, an idle or delayed voice only the read step;
// a last step saturates and posts the mix once the output register is free.
// The result sits in an output register, so the next transaction is taken
// while it waits. The sample memory has no reset; the voice table comes out
// of reset with all voices free.
module multi_voice_sample_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] clip_length_i,
  input  logic [15:0] start_delay_i,
  input  logic signed [7:0]  speed_i,
  input  logic [15:0] load_address_i,
  input  logic signed [15:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] dac_word_o,
  output logic signed [15:0] mixed_value_o
);

  localparam int unsigned NV    = mvsm_pkg::VOICES;
  localparam int unsigned VW    = mvsm_pkg::VIDX_W;
  localparam int unsigned AW    = mvsm_pkg::ADDR_W;
  localparam int unsigned SW    = mvsm_pkg::SUM_W;
  localparam int unsigned PW    = mvsm_pkg::POS_W;
  localparam int unsigned PHW   = mvsm_pkg::PHASE_W;
  localparam int unsigned SPW   = mvsm_pkg::SPEED_W;

  mvsm_pkg::state_e state_q, state_d;

  // voice table
  logic                  busy_q  [NV];
  logic [15:0]           base_q  [NV];
  logic [15:0]           len_q   [NV];
  logic [15:0]           delay_q [NV];
  logic [PW-1:0]         pos_q   [NV];
  logic signed [PHW-1:0] phase_q [NV];
  logic signed [SPW-1:0] speed_q [NV];

  logic [15:0]           mem [mvsm_pkg::SAMPLE_WORDS];
  logic [15:0]           rdata_q;

  // captured queue transaction
  mvsm_pkg::cmd_e        cmd_q;
  logic [15:0]           start_q, clen_q, sdly_q;
  logic signed [SPW-1:0] spd_q;

  logic [VW-1:0]         vidx_q;
  logic                  dup_q, found_q;
  logic [VW-1:0]         free_q;
  logic signed [SW-1:0]  sum_q;
  logic signed [15:0]    last_q;

  logic                  out_valid_q;
  logic [15:0]           dac_q;
  logic signed [15:0]    mix_q;

  logic                  in_fire, load_we, last_voice, out_free, post_mix;
  logic [AW-1:0]         raddr;
  logic signed [PHW-1:0] phase_nx;
  logic [PW-1:0]         pos_inc;
  logic [PW-1:0]         pos_nx;
  logic signed [SW-1:0]  shifted;
  logic signed [15:0]    mix_sat;
  logic [15:0]           mix_ob;

  assign in_ready_o = (state_q == mvsm_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_we    = in_fire && (mvsm_pkg::cmd_e'(cmd_i) == mvsm_pkg::CMD_LOAD);
  assign last_voice = (vidx_q == VW'(NV - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign post_mix   = (state_q == mvsm_pkg::S_FIN) && out_free && (mix_sat != last_q);
  // offset binary view of the mix
  assign mix_ob     = mix_sat ^ mvsm_pkg::SIGN_FLIP;

  assign raddr = AW'(base_q[vidx_q] + pos_q[vidx_q][15:0]);

  // phase and position step of the voice under the counter
  always_comb begin
    phase_nx = phase_q[vidx_q] + PHW'(speed_q[vidx_q]);
    pos_inc  = pos_q[vidx_q] + PW'(1);
    pos_nx   = pos_inc;
    if (phase_nx > mvsm_pkg::PHASE_HI) begin
      pos_nx = pos_q[vidx_q] + PW'(2);
    end else if (phase_nx < mvsm_pkg::PHASE_LO) begin
      pos_nx = pos_q[vidx_q];
    end
  end

  // floor divide by four, then clamp to 16 bits
  always_comb begin
    shifted = sum_q >>> 2;
    if (shifted > mvsm_pkg::MIX_MAX) begin
      mix_sat = 16'sh7FFF;
    end else if (shifted < mvsm_pkg::MIX_MIN) begin
      mix_sat = -16'sh8000;
    end else begin
      mix_sat = shifted[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mvsm_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (mvsm_pkg::cmd_e'(cmd_i))
            mvsm_pkg::CMD_TICK:  state_d = mvsm_pkg::S_TRD;
            mvsm_pkg::CMD_LOAD:  state_d = mvsm_pkg::S_IDLE;
            default:             state_d = mvsm_pkg::S_SCAN;
          endcase
        end
      end
      mvsm_pkg::S_SCAN:  if (last_voice) state_d = mvsm_pkg::S_CLAIM;
      mvsm_pkg::S_CLAIM: state_d = mvsm_pkg::S_IDLE;
      mvsm_pkg::S_TRD: begin
        if (busy_q[vidx_q] && (delay_q[vidx_q] == '0)) begin
          state_d = mvsm_pkg::S_TACC;
        end else if (last_voice) begin
          state_d = mvsm_pkg::S_FIN;
        end
      end
      mvsm_pkg::S_TACC:  state_d = last_voice ? mvsm_pkg::S_FIN : mvsm_pkg::S_TRD;
      mvsm_pkg::S_FIN:   if (out_free) state_d = mvsm_pkg::S_IDLE;
      default:           state_d = mvsm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvsm_pkg::S_IDLE;
      vidx_q      <= '0;
      dup_q       <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        busy_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (post_mix) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        mvsm_pkg::S_IDLE: begin
          vidx_q  <= '0;
          dup_q   <= 1'b0;
          found_q <= 1'b0;
          sum_q   <= '0;
        end
        mvsm_pkg::S_SCAN: begin
          if (busy_q[vidx_q] && (base_q[vidx_q] == start_q)) begin
            dup_q <= 1'b1;
          end
          if (!busy_q[vidx_q] && !found_q) begin
            found_q <= 1'b1;
            free_q  <= vidx_q;
          end
          if (!last_voice) vidx_q <= vidx_q + VW'(1);
        end
        mvsm_pkg::S_CLAIM: begin
          if (found_q && !(dup_q && (cmd_q == mvsm_pkg::CMD_QUEUE_ONCE))) begin
            busy_q[free_q] <= 1'b1;
          end
        end
        mvsm_pkg::S_TRD: begin
          if (busy_q[vidx_q] && (delay_q[vidx_q] != '0)) begin
            // still waiting out the start delay
          end
          if (!(busy_q[vidx_q] && (delay_q[vidx_q] == '0)) && !last_voice) begin
            vidx_q <= vidx_q + VW'(1);
          end
        end
        mvsm_pkg::S_TACC: begin
          sum_q <= sum_q + SW'(signed'(rdata_q));
          if (pos_nx >= PW'(len_q[vidx_q])) begin
            busy_q[vidx_q] <= 1'b0;
          end
          if (!last_voice) vidx_q <= vidx_q + VW'(1);
        end
        mvsm_pkg::S_FIN: begin
          if (post_mix) begin
            last_q <= mix_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // voice payload and captured command, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= mvsm_pkg::cmd_e'(cmd_i);
      start_q <= start_address_i;
      clen_q  <= clip_length_i;
      sdly_q  <= start_delay_i;
      spd_q   <= speed_i;
    end
    if ((state_q == mvsm_pkg::S_CLAIM) && found_q &&
        !(dup_q && (cmd_q == mvsm_pkg::CMD_QUEUE_ONCE))) begin
      base_q[free_q]  <= start_q;
      len_q[free_q]   <= clen_q;
      delay_q[free_q] <= sdly_q;
      pos_q[free_q]   <= '0;
      phase_q[free_q] <= '0;
      speed_q[free_q] <= spd_q;
    end
    if ((state_q == mvsm_pkg::S_TRD) && busy_q[vidx_q] && (delay_q[vidx_q] != '0)) begin
      delay_q[vidx_q] <= delay_q[vidx_q] - 16'd1;
    end
    if (state_q == mvsm_pkg::S_TACC) begin
      pos_q[vidx_q] <= pos_nx;
      if ((phase_nx > mvsm_pkg::PHASE_HI) || (phase_nx < mvsm_pkg::PHASE_LO)) begin
        phase_q[vidx_q] <= '0;
      end else begin
        phase_q[vidx_q] <= phase_nx;
      end
    end
    if (post_mix) begin
      mix_q <= mix_sat;
      dac_q <= mvsm_pkg::DAC_CTRL | ({4'b0, mix_ob[15:4]} & mvsm_pkg::DAC_MASK);
    end
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[AW'(load_address_i)] <= load_value_i;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign dac_word_o    = dac_q;
  assign mixed_value_o = mix_q;

  // a new result only comes out of the mix step
  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == mvsm_pkg::S_FIN))
    else $error("result posted outside the mix step");

  // the pending result is always the last value sent
  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mixed_value_o == last_q))
    else $error("pending mix differs from last sent value");

  // control bits of the dac word are fixed
  a_dac_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dac_word_o[15:12] == mvsm_pkg::DAC_CTRL[15:12]))
    else $error("dac control bits wrong");

  // voice counter is parked at zero when idle
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvsm_pkg::S_IDLE) && $past(state_q == mvsm_pkg::S_IDLE) |-> (vidx_q == '0))
    else $error("voice counter not cleared in idle");

endmodule

// File: dv/multi_voice_sample_mixer_tb.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_tb
// Self-checking bench for the sample mixer. A short table of hand-picked
// transactions (saturation, address wrap, zero-length clips, queue drops)
// runs first. Random loads, queues and ticks follow. Every accepted command
// goes through a behavioral model of the voice table; each DAC output is
// checked in order against it or against a directed row's typed value. Both
// handshakes idle at random, and the output holds off once for a long stretch.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_tb;

  localparam logic [15:0] WIN_BASE     = 16'hFFC0;  // clip bank, crosses the wrap
  localparam int unsigned WIN_WORDS    = 128;
  localparam int unsigned RAND_ITEMS   = 1500;
  localparam int unsigned DRAIN_CYCLES = 8 * mvsm_pkg::VOICES + 64;
  localparam int unsigned HOLD_AFTER   = 40;
  localparam int unsigned HOLD_CYCLES  = 600;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_VALUE
  } chk_e;

  typedef struct {
    mvsm_pkg::cmd_e     cmd;
    logic [15:0]        start;
    logic [15:0]        len;
    logic [15:0]        dly;
    logic signed [7:0]  spd;
    logic [15:0]        laddr;
    logic signed [15:0] lval;
  } voice_cmd_t;

  typedef struct {
    logic [15:0] dac;
    logic [15:0] mix;
  } dac_sample_t;

  typedef struct {
    voice_cmd_t  c;
    chk_e        kind;
    dac_sample_t exp_s;
  } table_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [15:0]        start_address_i;
  logic [15:0]        clip_length_i;
  logic [15:0]        start_delay_i;
  logic signed [7:0]  speed_i;
  logic [15:0]        load_address_i;
  logic signed [15:0] load_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [15:0]        dac_word_o;
  logic signed [15:0] mixed_value_o;

  // voice table and sample store as the mixer should hold them
  bit [15:0]     v_base  [mvsm_pkg::VOICES];
  bit [15:0]     v_len   [mvsm_pkg::VOICES];
  bit [15:0]     v_wait  [mvsm_pkg::VOICES];
  bit [mvsm_pkg::POS_W-1:0] v_pos [mvsm_pkg::VOICES];
  bit            v_busy  [mvsm_pkg::VOICES];
  int            v_phase [mvsm_pkg::VOICES];
  int            v_step  [mvsm_pkg::VOICES];
  logic [15:0]   mem_words [mvsm_pkg::SAMPLE_WORDS];
  int            last_level;

  dac_sample_t   pending_samples[$];
  table_row_t    directed_rows[$];
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   items_sent;
  int unsigned   burst_left;

  multi_voice_sample_mixer u_dut (.*);

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // applies one command to the model; returns 1 when a DAC word goes out
  function automatic bit mix_and_update(input voice_cmd_t c, output dac_sample_t s);
    bit                          found;
    int                          sum;
    int                          lvl;
    logic [mvsm_pkg::ADDR_W-1:0] addr;
    s     = '{dac: '0, mix: '0};
    found = 1'b0;
    sum   = 0;
    if (c.cmd == mvsm_pkg::CMD_LOAD) begin
      mem_words[mvsm_pkg::ADDR_W'(c.laddr)] = c.lval;
      return 1'b0;
    end
    if (c.cmd == mvsm_pkg::CMD_QUEUE || c.cmd == mvsm_pkg::CMD_QUEUE_ONCE) begin
      // single queue is dropped when the clip is already playing
      if (c.cmd == mvsm_pkg::CMD_QUEUE_ONCE) begin
        for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
          if (v_busy[v] && v_base[v] == c.start) found = 1'b1;
        end
      end
      for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
        if (!found && !v_busy[v]) begin
          found      = 1'b1;
          v_busy[v]  = 1'b1;
          v_base[v]  = c.start;
          v_len[v]   = c.len;
          v_wait[v]  = c.dly;
          v_pos[v]   = '0;
          v_phase[v] = 0;
          v_step[v]  = int'(c.spd);
        end
      end
      return 1'b0;
    end
    for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
      if (v_busy[v]) begin
        if (v_wait[v] != 0) begin
          v_wait[v]--;
        end else begin
          addr = mvsm_pkg::ADDR_W'(v_base[v] + v_pos[v]);
          sum += int'($signed(mem_words[addr]));
          v_pos[v]   = v_pos[v] + 1'b1;
          v_phase[v] = v_phase[v] + v_step[v];
          if (v_phase[v] > mvsm_pkg::PHASE_HI) begin
            v_pos[v]   = v_pos[v] + 1'b1;
            v_phase[v] = 0;
          end
          if (v_phase[v] < mvsm_pkg::PHASE_LO) begin
            v_pos[v]   = v_pos[v] - 1'b1;
            v_phase[v] = 0;
          end
          if (v_pos[v] >= {1'b0, v_len[v]}) v_busy[v] = 1'b0;
        end
      end
    end
    lvl = sum >>> 2;
    if (lvl > mvsm_pkg::MIX_MAX) lvl = mvsm_pkg::MIX_MAX;
    if (lvl < mvsm_pkg::MIX_MIN) lvl = mvsm_pkg::MIX_MIN;
    if (lvl == last_level) return 1'b0;
    last_level = lvl;
    s.dac = mvsm_pkg::DAC_CTRL | (16'((lvl + 32768) >>> 4) & mvsm_pkg::DAC_MASK);
    s.mix = 16'(lvl);
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_row(input mvsm_pkg::cmd_e cmd, input logic [15:0] start,
                                  input logic [15:0] len, input logic [15:0] dly,
                                  input logic signed [7:0] spd, input logic [15:0] laddr,
                                  input logic signed [15:0] lval, input chk_e kind,
                                  input logic [15:0] dac, input logic [15:0] mix);
    table_row_t r;
    r.c     = '{cmd: cmd, start: start, len: len, dly: dly, spd: spd,
                laddr: laddr, lval: lval};
    r.kind  = kind;
    r.exp_s = '{dac: dac, mix: mix};
    directed_rows.push_back(r);
  endfunction

  // clips only ever cover the preloaded bank, so no unwritten word is played
  function automatic voice_cmd_t next_random_cmd(input int idx);
    voice_cmd_t  c;
    int unsigned roll;
    int unsigned off;
    int unsigned room;
    int          busy_ids[$];
    c.cmd   = mvsm_pkg::CMD_TICK;
    c.start = 16'($urandom);
    c.len   = 16'($urandom);
    c.dly   = 16'($urandom);
    c.spd   = 8'($urandom);
    c.laddr = 16'($urandom);
    c.lval  = 16'($urandom);
    if (idx < WIN_WORDS) begin
      c.cmd   = mvsm_pkg::CMD_LOAD;
      c.laddr = WIN_BASE + 16'(idx);
      c.lval  = pick_sample();
      return c;
    end
    for (int v = 0; v < mvsm_pkg::VOICES; v++) begin
      if (v_busy[v]) busy_ids.push_back(v);
    end
    if (burst_left == 0 && $urandom_range(0, 49) == 0) burst_left = $urandom_range(8, 12);
    roll = $urandom_range(0, 99);
    if (burst_left != 0 || roll < 18) begin
      if (burst_left != 0) burst_left--;
      c.cmd = ($urandom_range(0, 1) != 0) ? mvsm_pkg::CMD_QUEUE_ONCE : mvsm_pkg::CMD_QUEUE;
      // with the table full anything goes, it is dropped
      if (busy_ids.size() == mvsm_pkg::VOICES && $urandom_range(0, 1) != 0) return c;
      off     = $urandom_range(0, WIN_WORDS - 1);
      room    = WIN_WORDS - off;
      c.start = WIN_BASE + 16'(off);
      if ($urandom_range(0, 9) == 0) c.len = 16'($urandom_range(0, room));
      else c.len = 16'($urandom_range(0, (room > 12) ? 12 : room));
      if ($urandom_range(0, 9) == 0) c.dly = 16'($urandom_range(0, 60));
      else c.dly = 16'($urandom_range(0, 3));
      // a step below -100 never advances, keep such clips one-shot
      if (c.spd < -8'sd100) c.len = '0;
      if (c.cmd == mvsm_pkg::CMD_QUEUE_ONCE && busy_ids.size() != 0 &&
          $urandom_range(0, 2) == 0) begin
        c.start = v_base[busy_ids[$urandom_range(0, busy_ids.size() - 1)]];
      end
    end else if (roll < 33) begin
      c.cmd = mvsm_pkg::CMD_LOAD;
      if ($urandom_range(0, 1) != 0) c.laddr = WIN_BASE + 16'($urandom_range(0, WIN_WORDS - 1));
      c.lval = pick_sample();
    end
    return c;
  endfunction

  task automatic send_cmd(input voice_cmd_t c, input chk_e kind, input dac_sample_t typed);
    dac_sample_t s;
    bit          has;
    int unsigned gap;
    in_valid_i      <= 1'b1;
    cmd_i           <= c.cmd;
    start_address_i <= c.start;
    clip_length_i   <= c.len;
    start_delay_i   <= c.dly;
    speed_i         <= c.spd;
    load_address_i  <= c.laddr;
    load_value_i    <= c.lval;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has = mix_and_update(c, s);
    if (kind == CHK_MODEL && has) pending_samples.push_back(s);
    else if (kind == CHK_VALUE) pending_samples.push_back(typed);
    items_sent++;
    gap = ((items_sent / 200) % 4 == 3) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus_side
    dac_sample_t no_sample;
    no_sample       = '{dac: '0, mix: '0};
    mismatches      = 0;
    results_seen    = 0;
    items_sent      = 0;
    burst_left      = 0;
    last_level      = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    cmd_i           <= mvsm_pkg::CMD_TICK;
    start_address_i <= '0;
    clip_length_i   <= '0;
    start_delay_i   <= '0;
    speed_i         <= '0;
    load_address_i  <= '0;
    load_value_i    <= '0;

    // a zero mix right after reset matches the last word sent
    add_row(mvsm_pkg::CMD_TICK, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'h0000, 16'sh0000,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_LOAD, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'h0000, 16'sh7FFF,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_LOAD, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'hFFFF, 16'sh7FFF,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_LOAD, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'hFFFE, 16'sh7FFF,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_LOAD, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'h0001, 16'sh8000,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_LOAD, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'h8000, 16'sh8000,
            CHK_NONE, '0, '0);
    // five full-scale voices push the mix past the positive limit
    repeat (5) begin
      add_row(mvsm_pkg::CMD_QUEUE, 16'h0000, 16'd1, 16'd0, 8'sd0, 16'h0000, 16'sh0000,
              CHK_NONE, '0, '0);
    end
    add_row(mvsm_pkg::CMD_TICK, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'h0000, 16'sh0000,
            CHK_VALUE, 16'h3FFF, 16'h7FFF);
    // zero-length clips still play one word, here at the negative limit
    repeat (4) begin
      add_row(mvsm_pkg::CMD_QUEUE, 16'h8000, 16'd0, 16'd0, 8'sd0, 16'h0000, 16'sh0000,
              CHK_NONE, '0, '0);
    end
    add_row(mvsm_pkg::CMD_QUEUE, 16'h8000, 16'd0, 16'd0, -8'sd128, 16'h0000, 16'sh0000,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_TICK, 16'h0000, 16'd0, 16'd0, 8'sd0, 16'h0000, 16'sh0000,
            CHK_VALUE, 16'h3000, 16'h8000);
    // delayed clip across the top of memory, then a repeat of it that is dropped
    add_row(mvsm_pkg::CMD_QUEUE_ONCE, 16'hFFFE, 16'd4, 16'd2, 8'sd127, 16'h0000, 16'sh0000,
            CHK_NONE, '0, '0);
    add_row(mvsm_pkg::CMD_QUEUE_ONCE, 16'hFFFE, 16'd9, 16'd0, 8'sd0, 16'h0000, 16'sh0000,
            CHK_NONE, '0, '0);
    repeat (4) begin
      add_row(mvsm_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, -8'sd1, 16'hFFFF, 16'shFFFF,
              CHK_MODEL, '0, '0);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].c, directed_rows[i].kind, directed_rows[i].exp_s);
    end
    for (int i = 0; i < RAND_ITEMS; i++) send_cmd(next_random_cmd(i), CHK_MODEL, no_sample);

    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : result_side
    dac_sample_t want;
    int unsigned stall;
    int unsigned cyc;
    bit          held;
    stall = 0;
    cyc   = 0;
    held  = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_samples.size() == 0) begin
          $error("unexpected transaction: dac_word %h mixed_value %0d",
                 dac_word_o, mixed_value_o);
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (dac_word_o !== want.dac) begin
            $error("dac_word: expected %h, got %h", want.dac, dac_word_o);
            mismatches++;
          end
          if (mixed_value_o !== want.mix) begin
            $error("mixed_value: expected %0d, got %0d", $signed(want.mix), mixed_value_o);
            mismatches++;
          end
        end
      end
      // one long hold-off so the output register backs up into the input
      if (!held && results_seen >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else if (stall == 0 && (cyc / 1000) % 4 != 3 && $urandom_range(0, 3) == 0) begin
        stall = idle_len();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $error("run timed out with %0d transactions outstanding", pending_samples.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
